// ----- design/bras_pkg.sv -----
`default_nettype none
package bras_pkg;

  localparam int IDX_W = 17;
  localparam int VAL_W = 64;
  localparam int POS_W = 20;
  localparam int BLK_W = 18;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_ADD   = 2'd1,
    OP_QUERY = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    K_LOAD,
    K_ADD,
    K_QUERY,
    K_ERR
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [VAL_W-1:0]   value;
    logic [POS_W-1:0]   p1s;
    logic [POS_W-1:0]   p1e;
    logic [POS_W-1:0]   p2s;
    logic [POS_W-1:0]   p2e;
    logic [BLK_W-1:0]   k1;
    logic [BLK_W-1:0]   k2;
    logic [BLK_W-1:0]   wlo;
    logic [BLK_W-1:0]   wlast;
    logic               two_seg;
    logic               has_whole;
  } cmd_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_PUSH
  } front_state_t;

  typedef enum logic [3:0] {
    B_CLEAR,
    B_IDLE,
    B_LD_RD,
    B_LD_WR,
    B_SEG_HDR,
    B_SEG_LAT,
    B_SEG_RUN,
    B_SEG_DRAIN,
    B_SEG_WB,
    B_WH_RUN,
    B_WH_DRAIN,
    B_RESP
  } back_state_t;

endpackage
`default_nettype wire

// ----- design/bras_if.sv -----
`default_nettype none
interface bras_in_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    operation;
  logic [bras_pkg::IDX_W-1:0]    left_index;
  logic [bras_pkg::IDX_W-1:0]    right_index;
  logic signed [bras_pkg::VAL_W-1:0] operand_value;

  modport source (output valid, operation, left_index, right_index, operand_value,
                  input ready);
  modport sink (input valid, operation, left_index, right_index, operand_value,
                output ready);
endinterface

interface bras_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [bras_pkg::VAL_W-1:0] range_total;
  logic                              status;

  modport source (output valid, range_total, status, input ready);
  modport sink (input valid, range_total, status, output ready);
endinterface
`default_nettype wire

// ----- design/block_range_add_range_sum.sv -----
// Range add / range sum engine over an array held in fixed-size blocks.
// in_ch carries one word per operation: load element, range add, or range
// sum query, with 1-based indices. out_ch returns exactly one word per
// operation: the range sum for a query (zero otherwise) and a status bit
// that is set for a bad index, left beyond right, or an unknown operation.
// The front decodes a word, splits both indices into block and offset with a
// reciprocal multiply, and hands a command to a two-entry queue; a rejected
// word skips the split. The front takes a new word only once its command is
// in the queue. The back walks the element and block memories and takes the
// next command only from idle. A load reads, then writes the element; a range
// op walks each partial block (header, read latency, element run, drain,
// write-back), then the whole blocks, then responds; an error responds at once.
// The front decodes the next word while the back is busy.
// After reset the back clears the element memory, the block sums and the
// pending adds, one element per cycle, before it takes a command; input words
// still queue up in front. A stalled receiver holds the result in the output
// register and stalls the back; the front and queue keep filling until the
// queue is full.
`default_nettype none
module block_range_add_range_sum #(
  parameter int MAX_ELEMENTS = 65536,
  parameter int BLOCK_SIZE   = 256
) (
  input wire logic    clk,
  input wire logic    rst_n,
  bras_in_if.sink     in_ch,
  bras_out_if.source  out_ch
);
  import bras_pkg::*;

  cmd_t f_cmd, q_cmd;
  logic f_valid, f_ready, q_valid, q_ready;

  bras_front #(
    .MAX_ELEMENTS(MAX_ELEMENTS),
    .BLOCK_SIZE  (BLOCK_SIZE)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .cmd      (f_cmd),
    .cmd_valid(f_valid),
    .cmd_ready(f_ready)
  );

  bras_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_cmd  (f_cmd),
    .push_valid(f_valid),
    .push_ready(f_ready),
    .pop_cmd   (q_cmd),
    .pop_valid (q_valid),
    .pop_ready (q_ready)
  );

  bras_back #(
    .MAX_ELEMENTS(MAX_ELEMENTS),
    .BLOCK_SIZE  (BLOCK_SIZE)
  ) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_cmd  (q_cmd),
    .q_valid(q_valid),
    .q_ready(q_ready),
    .out_ch (out_ch)
  );

endmodule
`default_nettype wire

// ----- design/bras_front.sv -----
`default_nettype none
module bras_front #(
  parameter int MAX_ELEMENTS = 65536,
  parameter int BLOCK_SIZE   = 256
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  bras_in_if.sink              in_ch,
  output bras_pkg::cmd_t       cmd,
  output logic                 cmd_valid,
  input  wire logic            cmd_ready
);
  import bras_pkg::*;

  localparam int NB = (MAX_ELEMENTS + BLOCK_SIZE - 1) / BLOCK_SIZE;
  localparam int AW = $clog2(MAX_ELEMENTS);
  localparam int BW = (NB > 1) ? $clog2(NB) : 1;
  localparam int OW = $clog2(BLOCK_SIZE);
  localparam int QS = IDX_W + OW;
  localparam int MW = IDX_W + 1;
  localparam int PW = IDX_W + MW;
  localparam longint RECIP = ((longint'(1) << QS) + longint'(BLOCK_SIZE) - longint'(1)) /
                             longint'(BLOCK_SIZE);

  front_state_t     state_r, state_nxt;
  logic [IDX_W-1:0] da_r, da_nxt, db_r, db_nxt;
  logic [OW-1:0]    ra_r, ra_nxt, rb_r, rb_nxt;
  logic [IDX_W-1:0] a_r, a_nxt, b_r, b_nxt;
  kind_t            kind_r, kind_nxt;
  logic [VAL_W-1:0] val_r, val_nxt;
  logic             in_acc, li_bad, ri_bad, err;
  logic [PW-1:0]    qa_prod, qb_prod;
  logic [IDX_W-1:0] qa, qb, rem_a, rem_b;
  logic [BW-1:0]    ba, bb;
  logic [AW-1:0]    a_aw, b_aw, fend, p2s;
  logic [BW:0]      ba1;

  assign in_acc = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == F_IDLE);
  assign cmd_valid = (state_r == F_PUSH);

  always_comb begin
    li_bad = (in_ch.left_index == '0) || (32'(in_ch.left_index) > 32'(MAX_ELEMENTS));
    ri_bad = (in_ch.right_index == '0) || (32'(in_ch.right_index) > 32'(MAX_ELEMENTS));
    case (in_ch.operation)
      OP_LOAD:  err = li_bad;
      OP_ADD,
      OP_QUERY: err = li_bad || ri_bad || (in_ch.left_index > in_ch.right_index);
      default:  err = 1'b1;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      F_IDLE:  if (in_acc) state_nxt = err ? F_PUSH : F_DIV;
      F_DIV:   state_nxt = F_PUSH;
      F_PUSH:  if (cmd_ready) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_comb begin
    da_nxt   = da_r;
    db_nxt   = db_r;
    ra_nxt   = ra_r;
    rb_nxt   = rb_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    kind_nxt = kind_r;
    val_nxt  = val_r;
    qa_prod  = PW'(a_r) * PW'(RECIP);
    qb_prod  = PW'(b_r) * PW'(RECIP);
    qa       = IDX_W'(qa_prod >> QS);
    qb       = IDX_W'(qb_prod >> QS);
    rem_a    = a_r - IDX_W'(qa * IDX_W'(BLOCK_SIZE));
    rem_b    = b_r - IDX_W'(qb * IDX_W'(BLOCK_SIZE));
    case (state_r)
      F_IDLE: begin
        if (in_acc) begin
          a_nxt   = in_ch.left_index - IDX_W'(1);
          b_nxt   = in_ch.right_index - IDX_W'(1);
          val_nxt = in_ch.operand_value;
          if (err) kind_nxt = K_ERR;
          else if (in_ch.operation == OP_LOAD) kind_nxt = K_LOAD;
          else if (in_ch.operation == OP_ADD) kind_nxt = K_ADD;
          else kind_nxt = K_QUERY;
        end
      end
      F_DIV: begin
        da_nxt = qa;
        db_nxt = qb;
        ra_nxt = OW'(rem_a);
        rb_nxt = OW'(rem_b);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    ba   = BW'(da_r);
    bb   = BW'(db_r);
    a_aw = AW'(a_r);
    b_aw = AW'(b_r);
    fend = (ba == bb) ? b_aw : (a_aw + AW'(BLOCK_SIZE - 1) - AW'(ra_r));
    p2s  = b_aw - AW'(rb_r);
    ba1  = (BW+1)'(ba) + (BW+1)'(1);
    cmd.kind      = kind_r;
    cmd.value     = val_r;
    cmd.p1s       = POS_W'(a_aw);
    cmd.p1e       = POS_W'(fend);
    cmd.p2s       = POS_W'(p2s);
    cmd.p2e       = POS_W'(b_aw);
    cmd.k1        = BLK_W'(ba);
    cmd.k2        = BLK_W'(bb);
    cmd.wlo       = BLK_W'(ba1);
    cmd.wlast     = BLK_W'(bb - BW'(1));
    cmd.two_seg   = (ba != bb);
    cmd.has_whole = (ba1 < (BW+1)'(bb));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    da_r   <= da_nxt;
    db_r   <= db_nxt;
    ra_r   <= ra_nxt;
    rb_r   <= rb_nxt;
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    kind_r <= kind_nxt;
    val_r  <= val_nxt;
  end

endmodule
`default_nettype wire

// ----- design/bras_queue.sv -----
`default_nettype none
module bras_queue (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  bras_pkg::cmd_t push_cmd,
  input  wire logic      push_valid,
  output logic           push_ready,
  output bras_pkg::cmd_t pop_cmd,
  output logic           pop_valid,
  input  wire logic      pop_ready
);
  import bras_pkg::*;

  cmd_t       ent_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       do_push, do_pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_cmd    = ent_r[rp_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) wp_r <= ~wp_r;
      if (do_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
    if (do_push) ent_r[wp_r] <= push_cmd;
  end

endmodule
`default_nettype wire

// ----- design/bras_back.sv -----
`default_nettype none
module bras_back #(
  parameter int MAX_ELEMENTS = 65536,
  parameter int BLOCK_SIZE   = 256
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  bras_pkg::cmd_t q_cmd,
  input  wire logic      q_valid,
  output logic           q_ready,
  bras_out_if.source     out_ch
);
  import bras_pkg::*;

  localparam int NB = (MAX_ELEMENTS + BLOCK_SIZE - 1) / BLOCK_SIZE;
  localparam int AW = $clog2(MAX_ELEMENTS);
  localparam int BW = (NB > 1) ? $clog2(NB) : 1;

  logic [VAL_W-1:0] elem_mem [MAX_ELEMENTS];
  logic [VAL_W-1:0] bt_mem [NB];
  logic [VAL_W-1:0] pd_mem [NB];
  logic [VAL_W-1:0] elem_q_r, bt_q_r, pd_q_r;

  back_state_t      state_r, state_nxt;
  cmd_t             cmd_r, cmd_nxt;
  logic [AW-1:0]    p_r, p_nxt, e_r, e_nxt, d1_addr_r, d1_addr_nxt;
  logic [BW-1:0]    k_r, k_nxt, w1_k_r, w1_k_nxt;
  logic             seg2_r, seg2_nxt, d1_r, d1_nxt, w1_r, w1_nxt, w2_r, w2_nxt;
  logic [VAL_W-1:0] pend_r, pend_nxt, btot_r, btot_nxt, acc_r, acc_nxt;
  logic [VAL_W-1:0] total_r, total_nxt, prod_r, prod_nxt, bsum_r, bsum_nxt;
  logic             ov_r, ov_nxt, os_r, os_nxt;
  logic [VAL_W-1:0] ot_r, ot_nxt;

  logic [AW-1:0]    e_raddr, e_waddr;
  logic             e_we;
  logic [VAL_W-1:0] e_wdata;
  logic [BW-1:0]    b_raddr, b_waddr;
  logic             bt_we, pd_we;
  logic [VAL_W-1:0] bt_wdata, pd_wdata;
  logic             is_add;

  assign q_ready            = (state_r == B_IDLE);
  assign out_ch.valid       = ov_r;
  assign out_ch.range_total = ot_r;
  assign out_ch.status      = os_r;
  assign is_add             = (cmd_r.kind == K_ADD);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_CLEAR:     if (p_r == AW'(MAX_ELEMENTS - 1)) state_nxt = B_IDLE;
      B_IDLE: begin
        if (q_valid) begin
          case (q_cmd.kind)
            K_ERR:   state_nxt = B_RESP;
            K_LOAD:  state_nxt = B_LD_RD;
            default: state_nxt = B_SEG_HDR;
          endcase
        end
      end
      B_LD_RD:     state_nxt = B_LD_WR;
      B_LD_WR:     state_nxt = B_RESP;
      B_SEG_HDR:   state_nxt = B_SEG_LAT;
      B_SEG_LAT:   state_nxt = B_SEG_RUN;
      B_SEG_RUN:   if (p_r == e_r) state_nxt = B_SEG_DRAIN;
      B_SEG_DRAIN: state_nxt = B_SEG_WB;
      B_SEG_WB: begin
        if (!seg2_r && cmd_r.two_seg) state_nxt = B_SEG_HDR;
        else if (cmd_r.has_whole) state_nxt = B_WH_RUN;
        else state_nxt = B_RESP;
      end
      B_WH_RUN:    if (k_r == BW'(cmd_r.wlast)) state_nxt = B_WH_DRAIN;
      B_WH_DRAIN:  if (!w1_r && !w2_r) state_nxt = B_RESP;
      B_RESP:      if (!ov_r || out_ch.ready) state_nxt = B_IDLE;
      default:     state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    cmd_nxt     = cmd_r;
    p_nxt       = p_r;
    e_nxt       = e_r;
    k_nxt       = k_r;
    seg2_nxt    = seg2_r;
    d1_nxt      = 1'b0;
    d1_addr_nxt = p_r;
    w1_nxt      = 1'b0;
    w1_k_nxt    = k_r;
    w2_nxt      = 1'b0;
    pend_nxt    = pend_r;
    btot_nxt    = btot_r;
    acc_nxt     = acc_r;
    total_nxt   = total_r;
    prod_nxt    = VAL_W'(pd_q_r * VAL_W'(BLOCK_SIZE));
    bsum_nxt    = bt_q_r;
    ov_nxt      = ov_r && !out_ch.ready;
    ot_nxt      = ot_r;
    os_nxt      = os_r;
    e_raddr     = p_r;
    e_waddr     = d1_addr_r;
    e_we        = 1'b0;
    e_wdata     = elem_q_r + cmd_r.value;
    b_raddr     = k_r;
    b_waddr     = w1_k_r;
    bt_we       = 1'b0;
    pd_we       = 1'b0;
    bt_wdata    = btot_r + acc_r;
    pd_wdata    = pd_q_r + cmd_r.value;

    if (d1_r) begin
      if (is_add) begin
        e_we    = 1'b1;
        acc_nxt = acc_r + cmd_r.value;
      end else begin
        total_nxt = total_r + elem_q_r + pend_r;
      end
    end
    if (w1_r) begin
      if (is_add) pd_we = 1'b1;
      else w2_nxt = 1'b1;
    end
    if (w2_r) total_nxt = total_nxt + bsum_r + prod_r;

    case (state_r)
      B_CLEAR: begin
        e_waddr  = p_r;
        e_we     = 1'b1;
        e_wdata  = '0;
        b_waddr  = BW'(p_r);
        bt_we    = 1'b1;
        pd_we    = 1'b1;
        bt_wdata = '0;
        pd_wdata = '0;
        p_nxt    = p_r + AW'(1);
      end
      B_IDLE: begin
        if (q_valid) begin
          cmd_nxt   = q_cmd;
          total_nxt = '0;
          p_nxt     = AW'(q_cmd.p1s);
          e_nxt     = AW'(q_cmd.p1e);
          k_nxt     = BW'(q_cmd.k1);
          seg2_nxt  = 1'b0;
        end
      end
      B_LD_WR: begin
        e_waddr  = p_r;
        e_we     = 1'b1;
        e_wdata  = cmd_r.value;
        b_waddr  = k_r;
        bt_we    = 1'b1;
        bt_wdata = bt_q_r + cmd_r.value - elem_q_r;
      end
      B_SEG_LAT: begin
        pend_nxt = pd_q_r;
        btot_nxt = bt_q_r;
        acc_nxt  = '0;
      end
      B_SEG_RUN: begin
        d1_nxt = 1'b1;
        if (p_r != e_r) p_nxt = p_r + AW'(1);
      end
      B_SEG_WB: begin
        if (is_add) begin
          b_waddr = k_r;
          bt_we   = 1'b1;
        end
        if (!seg2_r && cmd_r.two_seg) begin
          seg2_nxt = 1'b1;
          p_nxt    = AW'(cmd_r.p2s);
          e_nxt    = AW'(cmd_r.p2e);
          k_nxt    = BW'(cmd_r.k2);
        end else begin
          k_nxt = BW'(cmd_r.wlo);
        end
      end
      B_WH_RUN: begin
        w1_nxt = 1'b1;
        if (k_r != BW'(cmd_r.wlast)) k_nxt = k_r + BW'(1);
      end
      B_RESP: begin
        if (!ov_r || out_ch.ready) begin
          ov_nxt = 1'b1;
          os_nxt = (cmd_r.kind == K_ERR);
          ot_nxt = (cmd_r.kind == K_QUERY) ? total_r : '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    elem_q_r <= elem_mem[e_raddr];
    bt_q_r   <= bt_mem[b_raddr];
    pd_q_r   <= pd_mem[b_raddr];
    if (e_we) elem_mem[e_waddr] <= e_wdata;
    if (bt_we) bt_mem[b_waddr] <= bt_wdata;
    if (pd_we) pd_mem[b_waddr] <= pd_wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_CLEAR;
      p_r     <= '0;
      k_r     <= '0;
      d1_r    <= 1'b0;
      w1_r    <= 1'b0;
      w2_r    <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      p_r     <= p_nxt;
      k_r     <= k_nxt;
      d1_r    <= d1_nxt;
      w1_r    <= w1_nxt;
      w2_r    <= w2_nxt;
      ov_r    <= ov_nxt;
    end
    cmd_r     <= cmd_nxt;
    e_r       <= e_nxt;
    seg2_r    <= seg2_nxt;
    d1_addr_r <= d1_addr_nxt;
    w1_k_r    <= w1_k_nxt;
    pend_r    <= pend_nxt;
    btot_r    <= btot_nxt;
    acc_r     <= acc_nxt;
    total_r   <= total_nxt;
    prod_r    <= prod_nxt;
    bsum_r    <= bsum_nxt;
    ot_r      <= ot_nxt;
    os_r      <= os_nxt;
  end

endmodule
`default_nettype wire

// ----- tb/block_range_add_range_sum_test.sv -----
`default_nettype none
module block_range_add_range_sum_test;
  import bras_pkg::*;

  localparam int NUM_ELEM   = 65536;
  localparam int BLK_SIZE   = 256;
  localparam int NUM_BLK    = NUM_ELEM / BLK_SIZE;
  localparam int SEG_LEN    = 12;
  localparam int IDLE_LIMIT = 300000;
  localparam int LONG_HOLD  = 2500;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic [63:0] total;
    logic        status;
  } outcome_t;

  logic clk;
  logic rst_n;

  bras_in_if  in_ch ();
  bras_out_if out_ch ();

  block_range_add_range_sum uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  logic [63:0] elem_val [0:NUM_ELEM-1];
  logic [63:0] blk_sum [0:NUM_BLK-1];
  logic [63:0] blk_tag [0:NUM_BLK-1];
  outcome_t    pending_q[$];
  int          hot_blk[10] = '{0, 1, 2, 7, 64, 127, 128, 200, 254, 255};

  int burst_left;
  int n_words, n_load, n_add, n_query, n_err, n_results;
  int n_mismatch;
  int idle_cycles;
  int hold_req, hold_seen, hold_left;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // predictor
  function automatic outcome_t apply_op(logic [1:0] op, logic [16:0] li, logic [16:0] ri,
                                        logic [63:0] v);
    outcome_t    res;
    int unsigned a, b, ba, bb, first_end, i;
    res.total  = '0;
    res.status = 1'b0;
    if (op == OP_LOAD) begin
      if (li < 1 || li > NUM_ELEM) begin
        res.status = 1'b1;
      end else begin
        a = li - 1;
        blk_sum[a / BLK_SIZE] += v - elem_val[a];
        elem_val[a] = v;
      end
    end else if (op == OP_ADD || op == OP_QUERY) begin
      if (li < 1 || ri < 1 || li > NUM_ELEM || ri > NUM_ELEM || li > ri) begin
        res.status = 1'b1;
      end else begin
        a = li - 1;
        b = ri - 1;
        ba = a / BLK_SIZE;
        bb = b / BLK_SIZE;
        first_end = (ba + 1) * BLK_SIZE - 1;
        if (first_end > b) first_end = b;
        for (i = a; i <= first_end; i++) begin
          if (op == OP_ADD) begin
            elem_val[i] += v;
            blk_sum[ba] += v;
          end else begin
            res.total += elem_val[i] + blk_tag[ba];
          end
        end
        if (ba != bb) begin
          for (i = bb * BLK_SIZE; i <= b; i++) begin
            if (op == OP_ADD) begin
              elem_val[i] += v;
              blk_sum[bb] += v;
            end else begin
              res.total += elem_val[i] + blk_tag[bb];
            end
          end
        end
        for (i = ba + 1; i < bb; i++) begin
          if (op == OP_ADD) blk_tag[i] += v;
          else res.total += blk_sum[i] + blk_tag[i] * BLK_SIZE;
        end
        if (op == OP_ADD) res.total = '0;
      end
    end else begin
      res.status = 1'b1;
    end
    return res;
  endfunction

  task automatic send_word(logic [1:0] op, logic [16:0] li, logic [16:0] ri, logic [63:0] v);
    int gap;
    if (burst_left <= 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_ch.valid         <= 1'b1;
    in_ch.operation     <= op;
    in_ch.left_index    <= li;
    in_ch.right_index   <= ri;
    in_ch.operand_value <= v;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    pending_q.push_back(apply_op(op, li, ri, v));
    burst_left--;
    n_words++;
    if (op == OP_LOAD) n_load++;
    else if (op == OP_ADD) n_add++;
    else if (op == OP_QUERY) n_query++;
    if (op == OP_UNUSED || li == 0 || li > NUM_ELEM ||
        (op != OP_LOAD && (ri == 0 || ri > NUM_ELEM || li > ri))) n_err++;
  endtask

  task automatic go_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [63:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 64'h7fff_ffff_ffff_ffff;
      1: return 64'h8000_0000_0000_0000;
      2: return 64'(int'($urandom_range(0, 200)) - 100);
      3: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // range whose end segments lie inside preloaded elements
  task automatic pick_range(output logic [16:0] li, output logic [16:0] ri);
    int x, y, t, p1, p2, base;
    x = hot_blk[$urandom_range(0, 9)];
    y = hot_blk[$urandom_range(0, 9)];
    if (x > y) begin
      t = x; x = y; y = t;
    end
    if (x == y) begin
      base = x * BLK_SIZE + ($urandom_range(0, 1) ? BLK_SIZE - SEG_LEN : 0);
      p1 = base + $urandom_range(0, SEG_LEN - 1);
      p2 = base + $urandom_range(0, SEG_LEN - 1);
      if (p1 > p2) begin
        t = p1; p1 = p2; p2 = t;
      end
    end else begin
      p1 = x * BLK_SIZE + BLK_SIZE - SEG_LEN + $urandom_range(0, SEG_LEN - 1);
      p2 = y * BLK_SIZE + $urandom_range(0, SEG_LEN - 1);
    end
    li = 17'(p1 + 1);
    ri = 17'(p2 + 1);
  endtask

  task automatic random_word();
    logic [16:0] li, ri;
    int          sel, b;
    sel = $urandom_range(0, 99);
    pick_range(li, ri);
    if (sel < 15) begin
      send_word(OP_LOAD, li, ri, pick_value());
    end else if (sel < 20) begin
      send_word(OP_LOAD, 17'($urandom_range(1, NUM_ELEM)), 17'($urandom), pick_value());
    end else if (sel < 55) begin
      send_word(OP_ADD, li, ri, pick_value());
    end else if (sel < 90) begin
      send_word(OP_QUERY, li, ri, {$urandom, $urandom});
    end else begin
      b = $urandom_range(0, 3);
      case (b)
        0: send_word(OP_UNUSED, li, ri, {$urandom, $urandom});
        1: send_word(2'($urandom_range(0, 2)), 17'($urandom_range(NUM_ELEM + 1,
                     131071)), ri, pick_value());
        2: send_word(2'($urandom_range(1, 2)), li, 17'($urandom_range(0, 1) ?
                     0 : $urandom_range(NUM_ELEM + 1, 131071)), pick_value());
        default: if (li != ri) send_word(2'($urandom_range(1, 2)), ri, li,
                                         pick_value());
                 else send_word(OP_QUERY, 17'd0, ri, pick_value());
      endcase
    end
  endtask

  task automatic test_preload();
    int k, j, base;
    for (k = 0; k < 10; k++) begin
      for (j = 0; j < SEG_LEN; j++) begin
        base = hot_blk[k] * BLK_SIZE;
        send_word(OP_LOAD, 17'(base + j + 1), 17'($urandom), {$urandom, $urandom});
        send_word(OP_LOAD, 17'(base + BLK_SIZE - SEG_LEN + j + 1), 17'($urandom),
                  {$urandom, $urandom});
      end
    end
  endtask

  task automatic test_directed();
    send_word(OP_LOAD, 17'd1, 17'd0, 64'h7fff_ffff_ffff_ffff);
    send_word(OP_LOAD, 17'd65536, 17'h1ffff, 64'h8000_0000_0000_0000);
    send_word(OP_QUERY, 17'd1, 17'd1, '1);
    send_word(OP_QUERY, 17'd65536, 17'd65536, '0);
    send_word(OP_LOAD, 17'd1, 17'd0, 64'd5);
    send_word(OP_QUERY, 17'd1, 17'd12, '0);
    send_word(OP_ADD, 17'd245, 17'd65292, 64'h7fff_ffff_ffff_ffff);
    send_word(OP_QUERY, 17'd245, 17'd65292, '0);
    send_word(OP_ADD, 17'd3, 17'd3, '1);
    send_word(OP_ADD, 17'd65281, 17'd65536, 64'h8000_0000_0000_0000);
    send_word(OP_QUERY, 17'd65530, 17'd65536, '0);
    send_word(OP_LOAD, 17'd65290, 17'd0, 64'd77);
    send_word(OP_QUERY, 17'd1, 17'd65292, '0);
    send_word(OP_LOAD, 17'd0, 17'd0, 64'd1);
    send_word(OP_LOAD, 17'd65537, 17'd0, 64'd1);
    send_word(OP_LOAD, 17'h1ffff, 17'h1ffff, '1);
    send_word(OP_ADD, 17'd5, 17'd4, 64'd1);
    send_word(OP_QUERY, 17'd0, 17'd3, '0);
    send_word(OP_QUERY, 17'd3, 17'd65537, '0);
    send_word(OP_QUERY, 17'd3, 17'h1ffff, '0);
    send_word(OP_ADD, 17'd1, 17'd0, 64'd1);
    send_word(OP_UNUSED, 17'd1, 17'd2, '1);
    send_word(OP_QUERY, 17'd1, 17'd65292, '0);
  endtask

  task automatic test_random(int count);
    repeat (count) random_word();
  endtask

  task automatic test_backpressure();
    hold_req <= hold_req + 1;
    repeat (40) random_word();
  endtask

  task automatic test_drain_pause();
    go_idle();
    wait (pending_q.size() == 0);
    @(posedge clk);
    repeat (30) random_word();
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      hold_left    <= 0;
      hold_seen    <= 0;
    end else if (hold_req != hold_seen) begin
      hold_seen    <= hold_req;
      hold_left    <= LONG_HOLD;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ((n_results / 64) % 2 == 0) ? 1'b1 : ($urandom_range(0, 2) != 0);
    end
  end

  always @(posedge clk) begin
    outcome_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      n_results <= n_results + 1;
      if (pending_q.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10)
          $display("unexpected result: total=%h status=%b", out_ch.range_total, out_ch.status);
      end else begin
        want = pending_q.pop_front();
        if (out_ch.range_total !== want.total || out_ch.status !== want.status) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("result mismatch: total exp=%h got=%h status exp=%b got=%b",
                     want.total, out_ch.range_total, want.status, out_ch.status);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles > IDLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int k;
    for (k = 0; k < NUM_ELEM; k++) begin
      elem_val[k] = '0;
    end
    for (k = 0; k < NUM_BLK; k++) begin
      blk_sum[k] = '0;
      blk_tag[k] = '0;
    end
    burst_left  = 0;
    n_words     = 0;
    n_load      = 0;
    n_add       = 0;
    n_query     = 0;
    n_err       = 0;
    n_results   = 0;
    n_mismatch  = 0;
    idle_cycles = 0;
    hold_req    = 0;
    rst_n               <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.operation     <= OP_LOAD;
    in_ch.left_index    <= '0;
    in_ch.right_index   <= '0;
    in_ch.operand_value <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_preload();
    test_directed();
    test_random(200);
    test_backpressure();
    test_drain_pause();
    test_random(250);
    go_idle();

    wait (pending_q.size() == 0);
    repeat (1000) @(posedge clk);
    if (pending_q.size() != 0) n_mismatch++;
    $display("covered %0d words: %0d loads, %0d range adds, %0d queries, %0d rejected",
             n_words, n_load, n_add, n_query, n_err);
    $display("checked %0d results, one long receiver stall and one full drain", n_results);
    if (n_mismatch == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ----- files.f -----
design/bras_pkg.sv
design/bras_if.sv
design/bras_front.sv
design/bras_queue.sv
design/bras_back.sv
design/block_range_add_range_sum.sv
tb/block_range_add_range_sum_test.sv
